// ----- sv/css_pkg.sv -----
package css_pkg;

   localparam int unsigned CharWidth = 16;

   localparam logic [CharWidth-1:0] CH_SLASH  = 16'h002F;
   localparam logic [CharWidth-1:0] CH_STAR   = 16'h002A;
   localparam logic [CharWidth-1:0] CH_DQUOTE = 16'h0022;
   localparam logic [CharWidth-1:0] CH_SQUOTE = 16'h0027;
   localparam logic [CharWidth-1:0] CH_BTICK  = 16'h0060;
   localparam logic [CharWidth-1:0] CH_BSLASH = 16'h005C;
   localparam logic [CharWidth-1:0] CH_NL     = 16'h000A;

   // lexer mode, one-hot
   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_LINE   = 6'b000010,
      MODE_BLOCK  = 6'b000100,
      MODE_DQ     = 6'b001000,
      MODE_SQ     = 6'b010000,
      MODE_TL     = 6'b100000
   } mode_type;

   // one result item as held in the result queue
   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 char_present;
      logic                 end_marker;
      logic                 well_terminated;
   } result_type;

endpackage

// ----- sv/comment_string_stripper_unit.sv -----
// comment and string literal stripper, one utf-16 code unit per transfer
//
// input channel (req_): req_in_char is the code unit, req_in_last marks the
// final code unit of a source; a transfer happens when req_valid and
// req_ready are both high
// result channel (rsp_): one result per transfer, either a character
// (rsp_char_present high) or the closing status (rsp_end_marker high, with
// rsp_well_terminated set when the source ended outside strings and block
// comments); one input gives zero to three results
// configuration: csr_write_en with csr_write_data writes remove_strings;
// the user must write it only while the block is idle, the block itself does
// not enforce this; reset value is 1 (literals dropped)
// throughput: one input per cycle while each input gives at most one result;
// the result channel moves one result per cycle, so inputs that give more
// results, or a stalled receiver, fill the four-entry result queue and
// req_ready drops until three entries are free again
// reset: lexer state returns to normal text, queue is emptied, rsp_valid low
module comment_string_stripper_unit
   import css_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CharWidth-1:0] req_in_char,
   input  logic                 req_in_last,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CharWidth-1:0] rsp_out_char,
   output logic                 rsp_char_present,
   output logic                 rsp_end_marker,
   output logic                 rsp_well_terminated,
   // configuration
   input  logic                 csr_write_en,
   input  logic                 csr_write_data
);

   localparam int unsigned QDepth = 4;
   localparam int unsigned PtrW   = $clog2(QDepth);
   localparam int unsigned CntW   = $clog2(QDepth + 1);
   localparam int unsigned NCand  = 4;

   // configuration register
   logic remove_strings_ff;

   // lexer state
   mode_type mode_ff, mode_in;
   logic     esc_ff, esc_in;
   logic     slash_ff, slash_in;
   logic     star_ff, star_in;

   // result queue
   result_type          queue_ff [QDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   logic req_xfer;
   logic rsp_xfer;

   // candidate results in stream order: flushed slash, current char,
   // slash still held at end, status
   logic       flush_slash;
   logic       emit_char;
   logic       end_slash;
   logic       well_term;
   logic       cand_valid [NCand];
   result_type cand_entry [NCand];
   logic [PtrW-1:0] cand_off [NCand];
   logic [CntW-1:0] push_n;

   logic is_slash, is_star, is_bslash, is_nl, is_quote;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // room for the worst case of three results
   assign req_ready = (count_ff <= CntW'(QDepth - 3));
   assign rsp_valid = (count_ff != '0);

   assign rsp_out_char        = queue_ff[rd_ptr_ff].out_char;
   assign rsp_char_present    = queue_ff[rd_ptr_ff].char_present;
   assign rsp_end_marker      = queue_ff[rd_ptr_ff].end_marker;
   assign rsp_well_terminated = queue_ff[rd_ptr_ff].well_terminated;

   assign is_slash  = (req_in_char == CH_SLASH);
   assign is_star   = (req_in_char == CH_STAR);
   assign is_bslash = (req_in_char == CH_BSLASH);
   assign is_nl     = (req_in_char == CH_NL);
   assign is_quote  = (req_in_char == CH_DQUOTE) || (req_in_char == CH_SQUOTE) ||
                      (req_in_char == CH_BTICK);

   // lexer step for the item on the input port
   always_comb begin
      mode_in     = mode_ff;
      esc_in      = esc_ff;
      slash_in    = slash_ff;
      star_in     = star_ff;
      flush_slash = 1'b0;
      emit_char   = 1'b0;

      unique case (mode_ff)
         MODE_LINE: begin
            if (is_nl) begin
               mode_in   = MODE_NORMAL;
               emit_char = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (star_ff && is_slash) begin
               mode_in = MODE_NORMAL;
               star_in = 1'b0;
            end else begin
               star_in = is_star;
            end
         end
         MODE_DQ, MODE_SQ: begin
            if (esc_ff) begin
               esc_in    = 1'b0;
               emit_char = !remove_strings_ff;
            end else if (is_bslash) begin
               esc_in    = 1'b1;
               emit_char = !remove_strings_ff;
            end else if ((mode_ff == MODE_DQ && req_in_char == CH_DQUOTE) ||
                         (mode_ff == MODE_SQ && req_in_char == CH_SQUOTE)) begin
               mode_in   = MODE_NORMAL;
               emit_char = !remove_strings_ff;
            end else if (is_nl) begin
               // newline closes an open quote and always goes through
               mode_in   = MODE_NORMAL;
               emit_char = 1'b1;
            end else begin
               emit_char = !remove_strings_ff;
            end
         end
         MODE_TL: begin
            if (esc_ff) begin
               esc_in    = 1'b0;
               emit_char = !remove_strings_ff;
            end else if (is_bslash) begin
               esc_in    = 1'b1;
               emit_char = !remove_strings_ff;
            end else if (req_in_char == CH_BTICK) begin
               mode_in   = MODE_NORMAL;
               emit_char = !remove_strings_ff;
            end else begin
               emit_char = !remove_strings_ff;
            end
         end
         default: begin
            // normal text: a held slash is resolved by this character
            mode_in = MODE_NORMAL;
            if (slash_ff && is_slash) begin
               slash_in = 1'b0;
               mode_in  = MODE_LINE;
            end else if (slash_ff && is_star) begin
               slash_in = 1'b0;
               mode_in  = MODE_BLOCK;
               star_in  = 1'b0;
            end else begin
               flush_slash = slash_ff;
               slash_in    = 1'b0;
               if (is_slash) begin
                  slash_in = 1'b1;
               end else if (is_quote) begin
                  esc_in    = 1'b0;
                  emit_char = !remove_strings_ff;
                  if (req_in_char == CH_DQUOTE) begin
                     mode_in = MODE_DQ;
                  end else if (req_in_char == CH_SQUOTE) begin
                     mode_in = MODE_SQ;
                  end else begin
                     mode_in = MODE_TL;
                  end
               end else begin
                  emit_char = 1'b1;
               end
            end
         end
      endcase

      // end of source: flush the slash, report status, start afresh
      end_slash = req_in_last && slash_in;
      well_term = (mode_in == MODE_NORMAL) || (mode_in == MODE_LINE);
      if (req_in_last) begin
         mode_in  = MODE_NORMAL;
         esc_in   = 1'b0;
         slash_in = 1'b0;
         star_in  = 1'b0;
      end
   end

   // candidate results and their places in the queue
   always_comb begin
      cand_valid[0] = flush_slash;
      cand_valid[1] = emit_char;
      cand_valid[2] = end_slash;
      cand_valid[3] = req_in_last;

      cand_entry[0] = '{out_char: CH_SLASH, char_present: 1'b1,
                        end_marker: 1'b0, well_terminated: 1'b0};
      cand_entry[1] = '{out_char: req_in_char, char_present: 1'b1,
                        end_marker: 1'b0, well_terminated: 1'b0};
      cand_entry[2] = '{out_char: CH_SLASH, char_present: 1'b1,
                        end_marker: 1'b0, well_terminated: 1'b0};
      cand_entry[3] = '{out_char: '0, char_present: 1'b0,
                        end_marker: 1'b1, well_terminated: well_term};

      cand_off[0] = '0;
      for (int k = 1; k < NCand; k++) begin
         cand_off[k] = cand_off[k-1] + PtrW'(cand_valid[k-1]);
      end
      push_n = CntW'(cand_off[NCand-1]) + CntW'(cand_valid[NCand-1]);
   end

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_xfer) begin
         wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
      end
      if (rsp_xfer) begin
         rd_ptr_in = rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + (req_xfer ? push_n : '0) - CntW'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remove_strings_ff <= 1'b1;
         mode_ff           <= MODE_NORMAL;
         esc_ff            <= 1'b0;
         slash_ff          <= 1'b0;
         star_ff           <= 1'b0;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         count_ff          <= '0;
      end else begin
         if (csr_write_en) begin
            remove_strings_ff <= csr_write_data;
         end
         if (req_xfer) begin
            mode_ff  <= mode_in;
            esc_ff   <= esc_in;
            slash_ff <= slash_in;
            star_ff  <= star_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < NCand; k++) begin
         if (req_xfer && cand_valid[k]) begin
            queue_ff[wr_ptr_ff + cand_off[k]] <= cand_entry[k];
         end
      end
   end

endmodule
